[hw/rtl/fmsl_pkg.sv]
package fmsl_pkg;

	localparam int MAX_STATIONS = 32;
	localparam int IDX_W = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
	localparam int CNT_W = $clog2(MAX_STATIONS + 1);

	localparam int FREQ_W = 27;
	localparam int LEVEL_W = 4;
	localparam int WORD_W = 14;
	localparam int PLL_SHIFT = 13;

	localparam logic [FREQ_W-1:0] BAND_LOW = FREQ_W'(87500000);
	localparam logic [FREQ_W-1:0] BAND_HIGH = FREQ_W'(108000000);
	localparam logic [FREQ_W:0] PLL_OFFSET = (FREQ_W + 1)'(225000);
	localparam logic [FREQ_W:0] NEAR_SPAN = (FREQ_W + 1)'(300000);
	localparam logic [LEVEL_W-1:0] MIN_LEVEL_RESET = LEVEL_W'(12);

	typedef enum logic [1:0] {
		FUNC_TUNE = 2'd0,
		FUNC_SCAN = 2'd1,
		FUNC_NEXT = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0] func;
		logic [FREQ_W-1:0] frequency_hz;
		logic [LEVEL_W-1:0] level;
		logic stereo;
		logic scan_start;
		logic scan_end;
	} item_t;

	typedef struct packed {
		logic tune_valid;
		logic [WORD_W-1:0] tune_word;
		logic [5:0] station_count;
		logic [4:0] selected_index;
		logic range_error;
		logic list_full;
	} result_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic read;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

[hw/rtl/fm_station_scan_list.sv]
// FM station list with direct tune, scan and next-station stepping. The block
// works on one item at a time, in steps: the accepting edge registers the
// item, the next edge updates the list and hit history, the next one does the
// registered read of the station memory, and the last forms the tune word into
// the result register. A new item is accepted only after the result of the last
// one has been loaded. The input is free again in the cycle after the result is
// loaded, even while that result still waits downstream. A finished item keeps
// the input stalled only as long as the result register is full and its beat
// is stalled. The station memory needs no clearing after reset: only entries
// below the station count are ever used for a tune. min_level may be written at
// any time the block is idle; cfg_ready is always high.
module fm_station_scan_list (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input fmsl_pkg::item_t item,
	output logic result_valid,
	input logic result_stall,
	output fmsl_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [fmsl_pkg::LEVEL_W-1:0] cfg_data
);

	fmsl_pkg::ctrl_cmd_t cmd;
	fmsl_pkg::dp_status_t status;
	logic cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;

	fmsl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.status(status),
		.cmd(cmd)
	);

	fmsl_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.item(item),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

[hw/rtl/fmsl_ctrl.sv]
module fmsl_ctrl (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input fmsl_pkg::dp_status_t status,
	output fmsl_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_READ = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		state_next = state_q;
		cmd = '0;
		item_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_next = ST_READ;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_next = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				if (status.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

[hw/rtl/fmsl_datapath.sv]
module fmsl_datapath (
	input logic clk,
	input logic arst_n,
	input fmsl_pkg::ctrl_cmd_t cmd,
	output fmsl_pkg::dp_status_t status,
	input fmsl_pkg::item_t item,
	input logic cfg_we,
	input logic [fmsl_pkg::LEVEL_W-1:0] cfg_data,
	output logic result_valid,
	input logic result_stall,
	output fmsl_pkg::result_t result
);

	fmsl_pkg::item_t item_q;
	logic [fmsl_pkg::LEVEL_W-1:0] min_level_q;
	logic [fmsl_pkg::CNT_W-1:0] total_q;
	logic [fmsl_pkg::IDX_W-1:0] sel_q;
	logic [fmsl_pkg::FREQ_W-1:0] last_freq_q;
	logic [fmsl_pkg::LEVEL_W-1:0] last_level_q;
	logic [fmsl_pkg::IDX_W-1:0] rd_addr_q;
	logic tune_mem_q;
	logic tune_direct_q;
	logic full_q;
	logic [fmsl_pkg::FREQ_W-1:0] rd_data_q;
	logic out_valid_q;
	fmsl_pkg::result_t out_q;

	logic [fmsl_pkg::FREQ_W-1:0] mem [fmsl_pkg::MAX_STATIONS];

	logic is_scan;
	logic is_next;
	logic [fmsl_pkg::CNT_W-1:0] tot0;
	logic [fmsl_pkg::FREQ_W-1:0] last_freq0;
	logic [fmsl_pkg::LEVEL_W-1:0] last_level0;
	logic hit;
	logic near;
	logic do_replace;
	logic do_append;
	logic do_drop;
	logic [fmsl_pkg::IDX_W-1:0] wr_addr;
	logic [fmsl_pkg::CNT_W-1:0] tot_new;
	logic [fmsl_pkg::CNT_W-1:0] sel_inc;
	logic [fmsl_pkg::IDX_W-1:0] sel_new;
	logic [fmsl_pkg::IDX_W-1:0] rd_addr_next;
	logic tune_mem_next;
	logic [fmsl_pkg::FREQ_W-1:0] tune_freq;
	logic [fmsl_pkg::FREQ_W:0] tune_sum;
	logic tune_req;
	logic in_band;
	logic out_free;
	logic load_out;

	always_comb begin
		is_scan = item_q.func == fmsl_pkg::FUNC_SCAN;
		is_next = item_q.func == fmsl_pkg::FUNC_NEXT;
		tot0 = (is_scan && item_q.scan_start) ? '0 : total_q;
		last_freq0 = item_q.scan_start ? '0 : last_freq_q;
		last_level0 = item_q.scan_start ? '0 : last_level_q;
		hit = is_scan && item_q.stereo && (item_q.level >= min_level_q);
		near = (tot0 != '0) &&
			({1'b0, item_q.frequency_hz} <= ({1'b0, last_freq0} + fmsl_pkg::NEAR_SPAN));
		do_replace = hit && near && (last_level0 <= item_q.level);
		do_append = hit && !near && (tot0 < fmsl_pkg::CNT_W'(fmsl_pkg::MAX_STATIONS));
		do_drop = hit && !near && !do_append;
		wr_addr = do_replace ? fmsl_pkg::IDX_W'(tot0 - fmsl_pkg::CNT_W'(1))
			: fmsl_pkg::IDX_W'(tot0);
		tot_new = tot0 + fmsl_pkg::CNT_W'(do_append);

		// The selection steps only when more than one station is held.
		sel_inc = fmsl_pkg::CNT_W'(sel_q) + fmsl_pkg::CNT_W'(1);
		sel_new = (sel_inc >= total_q) ? '0 : fmsl_pkg::IDX_W'(sel_inc);

		rd_addr_next = '0;
		tune_mem_next = 1'b0;
		if (is_scan && item_q.scan_end && (tot_new != '0)) begin
			tune_mem_next = 1'b1;
		end else if (is_next && (total_q == fmsl_pkg::CNT_W'(1))) begin
			tune_mem_next = 1'b1;
		end else if (is_next && (total_q > fmsl_pkg::CNT_W'(1))) begin
			tune_mem_next = 1'b1;
			rd_addr_next = sel_new;
		end
	end

	always_comb begin
		tune_freq = tune_mem_q ? rd_data_q : item_q.frequency_hz;
		tune_req = tune_mem_q || tune_direct_q;
		in_band = (tune_freq >= fmsl_pkg::BAND_LOW) && (tune_freq <= fmsl_pkg::BAND_HIGH);
		tune_sum = {1'b0, tune_freq} + fmsl_pkg::PLL_OFFSET;
		out_free = !out_valid_q || !result_stall;
		load_out = cmd.finish && out_free;
		status.out_free = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.exec && (do_replace || do_append)) begin
			mem[wr_addr] <= item_q.frequency_hz;
		end
		if (cmd.read) begin
			rd_data_q <= mem[rd_addr_q];
		end
		if (cmd.exec) begin
			rd_addr_q <= rd_addr_next;
			full_q <= do_drop;
		end
		if (load_out) begin
			out_q.tune_valid <= tune_req && in_band;
			out_q.tune_word <= (tune_req && in_band)
				? tune_sum[fmsl_pkg::PLL_SHIFT +: fmsl_pkg::WORD_W] : '0;
			out_q.station_count <= 6'(total_q);
			out_q.selected_index <= 5'(sel_q);
			out_q.range_error <= tune_req && !in_band;
			out_q.list_full <= full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q <= fmsl_pkg::MIN_LEVEL_RESET;
			total_q <= '0;
			sel_q <= '0;
			last_freq_q <= '0;
			last_level_q <= '0;
			tune_mem_q <= 1'b0;
			tune_direct_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				min_level_q <= cfg_data;
			end
			if (cmd.exec) begin
				total_q <= tot_new;
				if (is_next && (total_q > fmsl_pkg::CNT_W'(1))) begin
					sel_q <= sel_new;
				end
				if (hit) begin
					last_freq_q <= item_q.frequency_hz;
					last_level_q <= item_q.level;
				end else if (is_scan && item_q.scan_start) begin
					last_freq_q <= '0;
					last_level_q <= '0;
				end
				tune_mem_q <= tune_mem_next;
				tune_direct_q <= item_q.func == fmsl_pkg::FUNC_TUNE;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule

[hw/rtl/fmsl_checker.sv]
module fmsl_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input logic result_valid,
	input logic result_stall,
	input fmsl_pkg::result_t result
);

	// A result beat that is stalled stays offered.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	// An item is worked on alone, so the input stalls right after a beat.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input not stalled after an accepted beat");

	a_tune_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.tune_valid && result.range_error)
			&& (result.tune_valid || result.tune_word == '0))
		else $error("inconsistent tune fields");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.station_count <= 6'(fmsl_pkg::MAX_STATIONS))
		else $error("station count beyond capacity");

endmodule

bind fm_station_scan_list fmsl_checker u_fmsl_checker (.*);

[bench/tb_fm_station_scan_list.sv]
module tb_fm_station_scan_list;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 238;
	localparam int ITEM_BITS = $bits(fmsl_pkg::item_t);
	localparam logic [fmsl_pkg::FREQ_W-1:0] FREQ_ALL_ONES = '1;

	typedef struct {
		fmsl_pkg::item_t stim;
		bit typed;
		fmsl_pkg::result_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	fmsl_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	fmsl_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [fmsl_pkg::LEVEL_W-1:0] cfg_data = '0;

	// Mirror of the block's list and hit history.
	logic [fmsl_pkg::FREQ_W-1:0] station_freq [fmsl_pkg::MAX_STATIONS];
	int unsigned station_cnt = 0;
	int unsigned sel_idx = 0;
	int unsigned prev_hit_freq = 0;
	int unsigned prev_hit_level = 0;
	logic [fmsl_pkg::LEVEL_W-1:0] min_level_cfg = fmsl_pkg::MIN_LEVEL_RESET;

	fmsl_pkg::result_t expected_results [$];
	int items_sent = 0;
	int results_checked = 0;
	int fail_count = 0;
	int drops_seen = 0;
	int range_errors_seen = 0;
	int tunes_seen = 0;
	int quiet_cycles = 0;
	int idle_pct = 37;
	int hold_req = 0;
	int hold_served = 0;
	int hold_left = 0;

	row_t directed_rows [23] = '{
		'{'{fmsl_pkg::FUNC_NEXT, 27'd0, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{1'b0, 14'd0, 6'd0, 5'd0, 1'b0, 1'b0}},
		'{'{fmsl_pkg::FUNC_TUNE, 27'd87500000, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{1'b1, 14'd10708, 6'd0, 5'd0, 1'b0, 1'b0}},
		'{'{fmsl_pkg::FUNC_TUNE, 27'd108000000, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{1'b1, 14'd13211, 6'd0, 5'd0, 1'b0, 1'b0}},
		'{'{fmsl_pkg::FUNC_TUNE, 27'd87499999, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{1'b0, 14'd0, 6'd0, 5'd0, 1'b1, 1'b0}},
		'{'{fmsl_pkg::FUNC_TUNE, 27'd108000001, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{1'b0, 14'd0, 6'd0, 5'd0, 1'b1, 1'b0}},
		'{'{fmsl_pkg::FUNC_TUNE, 27'd0, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{1'b0, 14'd0, 6'd0, 5'd0, 1'b1, 1'b0}},
		'{'{fmsl_pkg::FUNC_TUNE, 27'h7FFFFFF, 4'hF, 1'b1, 1'b1, 1'b1}, 1'b1,
			'{1'b0, 14'd0, 6'd0, 5'd0, 1'b1, 1'b0}},
		'{'{fmsl_pkg::FUNC_NONE, 27'h7FFFFFF, 4'hF, 1'b1, 1'b1, 1'b1}, 1'b1,
			'{1'b0, 14'd0, 6'd0, 5'd0, 1'b0, 1'b0}},
		// A first scan: append, nearby replace, append, weaker nearby hit, misses.
		'{'{fmsl_pkg::FUNC_SCAN, 27'd90000000, 4'd15, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{fmsl_pkg::FUNC_SCAN, 27'd90300000, 4'd15, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{fmsl_pkg::FUNC_SCAN, 27'd90600001, 4'd13, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{fmsl_pkg::FUNC_SCAN, 27'd90700000, 4'd12, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{fmsl_pkg::FUNC_SCAN, 27'd95000000, 4'd15, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{fmsl_pkg::FUNC_SCAN, 27'd96000000, 4'd11, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		// Below the last hit counts as nearby and leaves an out-of-band entry.
		'{'{fmsl_pkg::FUNC_SCAN, 27'd50000000, 4'd15, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{fmsl_pkg::FUNC_NEXT, 27'd0, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{fmsl_pkg::FUNC_NEXT, 27'd0, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{fmsl_pkg::FUNC_NEXT, 27'h5555555, 4'hA, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
		'{'{fmsl_pkg::FUNC_SCAN, 27'd0, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
		'{'{fmsl_pkg::FUNC_SCAN, 27'd0, 4'd0, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
		'{'{fmsl_pkg::FUNC_NEXT, 27'd0, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{fmsl_pkg::FUNC_SCAN, 27'd100000000, 4'd15, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{fmsl_pkg::FUNC_NEXT, 27'd0, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b0, '0}
	};

	fm_station_scan_list u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic void issue_tune(input logic [fmsl_pkg::FREQ_W-1:0] f,
		inout fmsl_pkg::result_t r);
		if (f < fmsl_pkg::BAND_LOW || f > fmsl_pkg::BAND_HIGH) begin
			r.range_error = 1'b1;
		end else begin
			r.tune_valid = 1'b1;
			r.tune_word = fmsl_pkg::WORD_W'((32'(f) + 32'(fmsl_pkg::PLL_OFFSET))
				>> fmsl_pkg::PLL_SHIFT);
		end
	endfunction

	function automatic fmsl_pkg::result_t predict_station_result(fmsl_pkg::item_t it);
		fmsl_pkg::result_t r;
		bit near;
		r = '0;
		case (fmsl_pkg::func_t'(it.func))
			fmsl_pkg::FUNC_TUNE: issue_tune(it.frequency_hz, r);
			fmsl_pkg::FUNC_SCAN: begin
				if (it.scan_start) begin
					station_cnt = 0;
					prev_hit_freq = 0;
					prev_hit_level = 0;
				end
				if (it.stereo && it.level >= min_level_cfg) begin
					near = station_cnt > 0 &&
						32'(it.frequency_hz) <= prev_hit_freq + 32'(fmsl_pkg::NEAR_SPAN);
					if (near) begin
						if (prev_hit_level <= it.level)
							station_freq[station_cnt - 1] = it.frequency_hz;
					end else if (station_cnt < fmsl_pkg::MAX_STATIONS) begin
						station_freq[station_cnt] = it.frequency_hz;
						station_cnt++;
					end else begin
						r.list_full = 1'b1;
					end
					prev_hit_freq = it.frequency_hz;
					prev_hit_level = it.level;
				end
				if (it.scan_end && station_cnt > 0)
					issue_tune(station_freq[0], r);
			end
			fmsl_pkg::FUNC_NEXT: begin
				if (station_cnt == 1) begin
					issue_tune(station_freq[0], r);
				end else if (station_cnt > 1) begin
					sel_idx++;
					if (sel_idx >= station_cnt)
						sel_idx = 0;
					issue_tune(station_freq[sel_idx], r);
				end
			end
			default: ;
		endcase
		r.station_count = station_cnt[5:0];
		r.selected_index = sel_idx[4:0];
		return r;
	endfunction

	// Holds the beat until it is taken, then at random drops valid and idles before
	// returning; otherwise valid is left up for the caller to offer the next beat.
	task automatic send_item(input fmsl_pkg::item_t it, input bit typed = 1'b0,
		input fmsl_pkg::result_t want = '0);
		fmsl_pkg::result_t pred;
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		pred = predict_station_result(it);
		expected_results.push_back(typed ? want : pred);
		if (fmsl_pkg::func_t'(it.func) != fmsl_pkg::FUNC_NONE)
			items_sent++;
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic write_min_level(input logic [fmsl_pkg::LEVEL_W-1:0] value);
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		min_level_cfg = value;
		cfg_valid <= 1'b0;
	endtask

	// One scan from start to end, with random content; a few are left broken.
	task automatic run_scan_sweep();
		int n;
		int k;
		int unsigned f;
		int pick;
		bit long_sweep;
		bit broken;
		fmsl_pkg::item_t it;
		long_sweep = $urandom_range(99) < 15;
		broken = $urandom_range(99) < 12;
		n = long_sweep ? $urandom_range(34, 48) : $urandom_range(1, 20);
		case ($urandom_range(3))
			0: f = $urandom_range(86000000, 87600000);
			1: f = fmsl_pkg::BAND_LOW;
			2: f = $urandom_range(87500000, 105000000);
			default: f = $urandom_range(106000000, 108000000);
		endcase
		for (k = 0; k < n; k++) begin
			it.func = fmsl_pkg::FUNC_SCAN;
			it.frequency_hz = f[fmsl_pkg::FREQ_W-1:0];
			if ($urandom_range(99) < 70)
				it.level = fmsl_pkg::LEVEL_W'($urandom_range(min_level_cfg, 15));
			else
				it.level = fmsl_pkg::LEVEL_W'($urandom_range(15));
			it.stereo = $urandom_range(99) < 85;
			it.scan_start = (k == 0);
			it.scan_end = (k == n - 1);
			if (broken) begin
				it.scan_start = $urandom_range(99) < 8;
				it.scan_end = $urandom_range(99) < 8;
			end
			send_item(it);
			pick = $urandom_range(99);
			if (long_sweep)
				f = f + $urandom_range(310000, 600000);
			else if (pick < 70)
				f = f + $urandom_range(50000, 700000);
			else if (pick < 85)
				f = f - $urandom_range(0, 200000);
			else
				f = f + 300000 + $urandom_range(1);
			f = f & 32'(FREQ_ALL_ONES);
		end
	endtask

	task automatic run_random_burst();
		fmsl_pkg::item_t it;
		int pick;
		int n;
		int k;
		pick = $urandom_range(99);
		it = fmsl_pkg::item_t'(ITEM_BITS'({$urandom, $urandom}));
		if (pick < 55) begin
			run_scan_sweep();
		end else if (pick < 75) begin
			n = $urandom_range(1, 6);
			for (k = 0; k < n; k++) begin
				it = fmsl_pkg::item_t'(ITEM_BITS'({$urandom, $urandom}));
				it.func = fmsl_pkg::FUNC_NEXT;
				send_item(it);
			end
		end else if (pick < 90) begin
			it.func = fmsl_pkg::FUNC_TUNE;
			case ($urandom_range(3))
				0: it.frequency_hz = fmsl_pkg::FREQ_W'($urandom);
				1: it.frequency_hz = fmsl_pkg::BAND_LOW
					+ fmsl_pkg::FREQ_W'($urandom_range(2)) - 1'b1;
				2: it.frequency_hz = fmsl_pkg::BAND_HIGH
					+ fmsl_pkg::FREQ_W'($urandom_range(2)) - 1'b1;
				default: it.frequency_hz =
					fmsl_pkg::FREQ_W'($urandom_range(87500000, 108000000));
			endcase
			send_item(it);
		end else if (pick < 95) begin
			it.func = fmsl_pkg::FUNC_NONE;
			send_item(it);
		end else begin
			send_item(it);
		end
	endtask

	// Receiver: checks every beat taken and drives its own stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected");
					fail_count++;
				end else begin
					fmsl_pkg::result_t want;
					want = expected_results.pop_front();
					results_checked++;
					if (result.tune_valid !== want.tune_valid) begin
						$error("tune_valid: expected %0d, got %0d", want.tune_valid,
							result.tune_valid);
						fail_count++;
					end
					if (result.tune_word !== want.tune_word) begin
						$error("tune_word: expected %0d, got %0d", want.tune_word,
							result.tune_word);
						fail_count++;
					end
					if (result.station_count !== want.station_count) begin
						$error("station_count: expected %0d, got %0d", want.station_count,
							result.station_count);
						fail_count++;
					end
					if (result.selected_index !== want.selected_index) begin
						$error("selected_index: expected %0d, got %0d", want.selected_index,
							result.selected_index);
						fail_count++;
					end
					if (result.range_error !== want.range_error) begin
						$error("range_error: expected %0d, got %0d", want.range_error,
							result.range_error);
						fail_count++;
					end
					if (result.list_full !== want.list_full) begin
						$error("list_full: expected %0d, got %0d", want.list_full,
							result.list_full);
						fail_count++;
					end
					drops_seen += want.list_full;
					range_errors_seen += want.range_error;
					tunes_seen += want.tune_valid;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (hold_served != hold_req) begin
				hold_served++;
				hold_left = HOLD_CYCLES - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= $urandom_range(99) < idle_pct;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
			(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** fm_station_scan_list: FAILED **");
			$finish;
		end
	end

	initial begin
		int r;
		int ph;
		int target;
		bit hold_done;
		int phase_level [PHASES];
		phase_level = '{0, 15, 12, -1, 3, -1};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < 23; r++)
			send_item(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);

		for (ph = 0; ph < PHASES; ph++) begin
			if (phase_level[ph] < 0)
				write_min_level(fmsl_pkg::LEVEL_W'($urandom_range(15)));
			else
				write_min_level(fmsl_pkg::LEVEL_W'(phase_level[ph]));
			// The third phase runs with both sides always ready.
			idle_pct <= (ph == 2) ? 0 : 37;
			target = items_sent + PHASE_ITEMS;
			hold_done = 1'b0;
			while (items_sent < target) begin
				if (ph == 4 && !hold_done && items_sent > target - 150) begin
					hold_req <= hold_req + 1;
					hold_done = 1'b1;
				end
				run_random_burst();
			end
		end

		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		$display("Ran %0d items through tune, scan and next-station with min_level from 0 to 15;",
			items_sent);
		$display("%0d results checked: %0d tunes, %0d range errors, %0d full-list drops.",
			results_checked, tunes_seen, range_errors_seen, drops_seen);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("** fm_station_scan_list: PASSED **");
		else
			$display("** fm_station_scan_list: FAILED **");
		$finish;
	end

endmodule
